// ----- sv/bac_pkg.sv -----
// Package: modes, microcode control word, microprogram ROM and dispatch table.
package bac_pkg;

  typedef enum logic [2:0] {
    MODE_ENC     = 3'd0,
    MODE_FLUSH   = 3'd1,
    MODE_DEC     = 3'd2,
    MODE_FEED    = 3'd3,
    MODE_RESTART = 3'd4
  } mode_t;

  typedef logic [3:0] uaddr_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_JUMP,
    C_MODE,
    C_NOAGREE,
    C_UNTIL3
  } cond_t;

  typedef enum logic [1:0] {
    EMIT_HIGH,
    EMIT_LOW,
    EMIT_DEC,
    EMIT_RST
  } emit_src_t;

  typedef struct packed {
    logic      mul;
    logic      mid;
    logic      apply;
    logic      dec;
    logic      shift;
    logic      flush;
    logic      feed;
    logic      restart;
    logic      emit;
    emit_src_t src;
    cond_t     cond;
    uaddr_t    target;
  } uword_t;

  typedef struct packed {
    logic go;
    logic cnt3;
    logic stall;
  } dp_status_t;

  localparam uaddr_t UA_DISPATCH = 4'd0;
  localparam uaddr_t UA_E_MUL    = 4'd1;
  localparam uaddr_t UA_E_MID    = 4'd2;
  localparam uaddr_t UA_E_APPLY  = 4'd3;
  localparam uaddr_t UA_E_LOOP   = 4'd4;
  localparam uaddr_t UA_E_EMIT   = 4'd5;
  localparam uaddr_t UA_F_EMIT   = 4'd6;
  localparam uaddr_t UA_D_MUL    = 4'd7;
  localparam uaddr_t UA_D_MID    = 4'd8;
  localparam uaddr_t UA_D_APPLY  = 4'd9;
  localparam uaddr_t UA_D_LOOP   = 4'd10;
  localparam uaddr_t UA_D_SHIFT  = 4'd11;
  localparam uaddr_t UA_D_EMIT   = 4'd12;
  localparam uaddr_t UA_FEED     = 4'd13;
  localparam uaddr_t UA_RESTART  = 4'd14;

  localparam logic [31:0] HIGH_RESET = 32'hFFFF_FFFF;
  localparam logic [7:0]  BYTE_ONES  = 8'hFF;
  localparam logic [2:0]  CNT_MAX    = 3'd4;
  localparam logic [2:0]  CNT_LAST   = 3'd3;

  function automatic uaddr_t entry(input logic [2:0] m);
    uaddr_t a;
    case (mode_t'(m))
      MODE_ENC:     a = UA_E_MUL;
      MODE_FLUSH:   a = UA_F_EMIT;
      MODE_DEC:     a = UA_D_MUL;
      MODE_FEED:    a = UA_FEED;
      MODE_RESTART: a = UA_RESTART;
      default:      a = UA_DISPATCH;
    endcase
    return a;
  endfunction

  function automatic uword_t rom(input uaddr_t a);
    uword_t w;
    w = '0;
    w.cond = C_NEXT;
    w.src = EMIT_HIGH;
    w.target = UA_DISPATCH;
    case (a)
      UA_DISPATCH: w.cond = C_MODE;
      UA_E_MUL:    w.mul = 1'b1;
      UA_E_MID:    w.mid = 1'b1;
      UA_E_APPLY:  w.apply = 1'b1;
      UA_E_LOOP:   w.cond = C_NOAGREE;
      UA_E_EMIT: begin
        w.emit = 1'b1;
        w.src = EMIT_HIGH;
        w.shift = 1'b1;
        w.cond = C_JUMP;
        w.target = UA_E_LOOP;
      end
      UA_F_EMIT: begin
        w.emit = 1'b1;
        w.src = EMIT_LOW;
        w.flush = 1'b1;
        w.cond = C_UNTIL3;
      end
      UA_D_MUL:    w.mul = 1'b1;
      UA_D_MID:    w.mid = 1'b1;
      UA_D_APPLY: begin
        w.apply = 1'b1;
        w.dec = 1'b1;
      end
      UA_D_LOOP: begin
        w.cond = C_NOAGREE;
        w.target = UA_D_EMIT;
      end
      UA_D_SHIFT: begin
        w.shift = 1'b1;
        w.cond = C_JUMP;
        w.target = UA_D_LOOP;
      end
      UA_D_EMIT: begin
        w.emit = 1'b1;
        w.src = EMIT_DEC;
        w.cond = C_JUMP;
      end
      UA_FEED: begin
        w.feed = 1'b1;
        w.cond = C_JUMP;
      end
      UA_RESTART: begin
        w.restart = 1'b1;
        w.emit = 1'b1;
        w.src = EMIT_RST;
        w.cond = C_JUMP;
      end
      default:     w.cond = C_JUMP;
    endcase
    return w;
  endfunction

endpackage

// ----- sv/bac_useq.sv -----
// Microcode sequencer: step counter, control ROM and branch logic.
module bac_useq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic [2:0]          in_mode,
  input  bac_pkg::dp_status_t st,
  output bac_pkg::uword_t     uw,
  output logic                in_tready
);

  bac_pkg::uaddr_t upc_r, upc_nxt;

  assign uw = bac_pkg::rom(upc_r);
  assign in_tready = (upc_r == bac_pkg::UA_DISPATCH);

  always_comb begin
    upc_nxt = upc_r;
    if (!st.stall) begin
      unique case (uw.cond)
        bac_pkg::C_NEXT:    upc_nxt = upc_r + 4'd1;
        bac_pkg::C_JUMP:    upc_nxt = uw.target;
        bac_pkg::C_MODE:    upc_nxt = in_tvalid ? bac_pkg::entry(in_mode) : upc_r;
        bac_pkg::C_NOAGREE: upc_nxt = st.go ? upc_r + 4'd1 : uw.target;
        bac_pkg::C_UNTIL3:  upc_nxt = st.cnt3 ? uw.target : upc_r;
        default:            upc_nxt = bac_pkg::UA_DISPATCH;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= bac_pkg::UA_DISPATCH;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

// ----- sv/bac_dpath.sv -----
// Coder datapath: bounds, code register, split multiplier and result register.
module bac_dpath (
  input  logic                clk,
  input  logic                rst_n,
  input  bac_pkg::uword_t     uw,
  input  logic                in_accept,
  input  logic                in_bit,
  input  logic [15:0]         in_prob,
  input  logic [7:0]          in_cbyte,
  input  logic                out_tready,
  output bac_pkg::dp_status_t st,
  output logic                out_tvalid,
  output logic [7:0]          out_byte,
  output logic                out_last,
  output logic                out_dbit,
  output logic [2:0]          out_need
);

  logic [31:0] low_r, low_nxt, high_r, high_nxt, code_r, code_nxt;
  logic [31:0] prod_hi_r, prod_lo_r, mid_r, range_w;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        bit_r, dbit_r, bit_w;
  logic [15:0] prob_r;
  logic [7:0]  cbyte_r;
  logic        ov_r, ov_nxt, ob_last_r;
  logic [7:0]  ob_byte_r;
  logic        ob_dbit_r;
  logic [2:0]  ob_need_r;
  logic        en, load;
  logic [7:0]  e_byte;
  logic        e_last, e_dbit;
  logic [2:0]  e_need;

  assign st.stall = uw.emit && ov_r && !out_tready;
  assign st.go    = (low_r[31:24] == high_r[31:24]) && (cnt_r != bac_pkg::CNT_MAX);
  assign st.cnt3  = (cnt_r == bac_pkg::CNT_LAST);
  assign en       = !st.stall;
  assign load     = uw.emit && en;

  assign range_w = high_r - low_r;
  assign bit_w   = uw.dec ? (code_r <= mid_r) : bit_r;

  always_comb begin
    e_byte = '0;
    e_last = 1'b1;
    e_dbit = 1'b0;
    e_need = '0;
    unique case (uw.src)
      bac_pkg::EMIT_HIGH: begin
        e_byte = high_r[31:24];
        e_last = (low_r[23:16] != high_r[23:16]) || (cnt_r == bac_pkg::CNT_LAST);
      end
      bac_pkg::EMIT_LOW: begin
        e_byte = low_r[31:24];
        e_last = (cnt_r == bac_pkg::CNT_LAST);
      end
      bac_pkg::EMIT_DEC: begin
        e_dbit = dbit_r;
        e_need = cnt_r;
      end
      bac_pkg::EMIT_RST: e_need = bac_pkg::CNT_MAX;
      default: e_last = 1'b1;
    endcase
  end

  always_comb begin
    low_nxt  = low_r;
    high_nxt = high_r;
    code_nxt = code_r;
    cnt_nxt  = cnt_r;
    if (in_accept) begin
      cnt_nxt = '0;
    end
    if (en) begin
      if (uw.apply) begin
        if (bit_w) begin
          high_nxt = mid_r;
        end else begin
          low_nxt = mid_r + 32'd1;
        end
      end
      if (uw.shift) begin
        low_nxt  = {low_r[23:0], 8'h00};
        high_nxt = {high_r[23:0], bac_pkg::BYTE_ONES};
        cnt_nxt  = cnt_r + 3'd1;
      end
      if (uw.flush) begin
        low_nxt = {low_r[23:0], 8'h00};
        cnt_nxt = cnt_r + 3'd1;
      end
      if (uw.feed) begin
        code_nxt = {code_r[23:0], cbyte_r};
      end
      if (uw.restart) begin
        low_nxt  = '0;
        high_nxt = bac_pkg::HIGH_RESET;
        code_nxt = '0;
      end
    end
  end

  always_comb begin
    ov_nxt = ov_r;
    if (load) begin
      ov_nxt = 1'b1;
    end else if (out_tready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= '0;
      high_r <= bac_pkg::HIGH_RESET;
      code_r <= '0;
      cnt_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      low_r  <= low_nxt;
      high_r <= high_nxt;
      code_r <= code_nxt;
      cnt_r  <= cnt_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      bit_r   <= in_bit;
      prob_r  <= in_prob;
      cbyte_r <= in_cbyte;
    end
    if (uw.mul) begin
      prod_hi_r <= {16'h0000, range_w[31:16]} * {16'h0000, prob_r};
      prod_lo_r <= {16'h0000, range_w[15:0]} * {16'h0000, prob_r};
    end
    if (uw.mid) begin
      mid_r <= low_r + prod_hi_r + {16'h0000, prod_lo_r[31:16]};
    end
    if (uw.apply && uw.dec) begin
      dbit_r <= bit_w;
    end
    if (load) begin
      ob_byte_r <= e_byte;
      ob_last_r <= e_last;
      ob_dbit_r <= e_dbit;
      ob_need_r <= e_need;
    end
  end

  assign out_tvalid = ov_r;
  assign out_byte   = ob_byte_r;
  assign out_last   = ob_last_r;
  assign out_dbit   = ob_dbit_r;
  assign out_need   = ob_need_r;

endmodule

// ----- sv/binary_arithmetic_coder.sv -----
// Top level of the carryless 32-bit binary arithmetic coder.
//   channel  dir  tdata                                         tuser      tlast
//   in_      in   [0] bit_value [16:1] prob_one [24:17] code    [2:0] mode  -
//   out_     out  [7:0] out_byte [8] decoded_bit [11:9] need    -          last_of_run
// Microprogram steps: encode does mul, mid, apply, then emits each settled high byte;
//   flush emits low bytes; decode does mul, mid, apply and shifts, then emits its result.
// in_tready is high only in the dispatch step; one item is worked at a time.
// A full result register with out_tready low holds the sequencer in its emit step.
// Reset is synchronous: bounds to 0 and 0xFFFFFFFF, code register 0, no result pending.
module binary_arithmetic_coder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // bit_value, prob_one, code_byte, zero pad
  input  logic [2:0]  in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // out_byte, decoded_bit, bytes_needed, zero pad
  output logic        out_tlast
);

  bac_pkg::uword_t     uw;
  bac_pkg::dp_status_t st;
  logic                in_accept;
  logic [7:0]          o_byte;
  logic                o_dbit;
  logic [2:0]          o_need;

  assign in_accept = in_tvalid && in_tready;

  bac_useq u_useq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_mode   (in_tuser),
    .st        (st),
    .uw        (uw),
    .in_tready (in_tready)
  );

  bac_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .uw         (uw),
    .in_accept  (in_accept),
    .in_bit     (in_tdata[0]),
    .in_prob    (in_tdata[16:1]),
    .in_cbyte   (in_tdata[24:17]),
    .out_tready (out_tready),
    .st         (st),
    .out_tvalid (out_tvalid),
    .out_byte   (o_byte),
    .out_last   (out_tlast),
    .out_dbit   (o_dbit),
    .out_need   (o_need)
  );

  assign out_tdata = {4'h0, o_need, o_dbit, o_byte};

endmodule

// ----- sv/bac_chk.sv -----
// Port-level checker for the coder, bound to the top level.
module bac_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [2:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser <= 3'd4) |=> !in_tready)
    else $error("ready while working an item");

  a_dbit_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[8] |-> out_tlast && (out_tdata[7:0] == 8'h00))
    else $error("decoded bit outside a single decode result");

  a_need_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[11:9] != 3'd0) |-> out_tlast && (out_tdata[11:9] <= 3'd4)
      && (out_tdata[7:0] == 8'h00))
    else $error("bad bytes_needed result");

endmodule

bind binary_arithmetic_coder bac_chk u_bac_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
